### sv/triangle_classify_measure_macros.svh
// assertion macros for the triangle classifier
`ifndef TRIANGLE_CLASSIFY_MEASURE_MACROS_SVH
`define TRIANGLE_CLASSIFY_MEASURE_MACROS_SVH
// implication checked every clock outside reset
`define TCM_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tcm check failed");
// next-cycle implication checked outside reset
`define TCM_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tcm check failed");
`endif

### sv/tcm_pkg.sv
// ----------------------------------------------------------------------------
// tcm_pkg
// widths, class codes and pipeline depth of the triangle classifier
// ----------------------------------------------------------------------------
package tcm_pkg;
  localparam int CoordBits = 16;
  localparam int FracBits  = 8;
  localparam int DiffBits  = CoordBits + 1;
  localparam int D2Bits    = 2 * DiffBits + 1;
  localparam int CrossBits = 2 * DiffBits + 1;
  localparam int RootBits  = 32 + FracBits;
  localparam int RootSteps = RootBits;
  localparam int RemBits   = RootBits + 2;
  localparam int PerimBits = 27;
  localparam int AreaBits  = 33;
  localparam int ClassBits = 3;
  localparam int Depth     = 5 + RootSteps;

  typedef enum logic [ClassBits-1:0] {
    CLS_NONE  = 3'd0,
    CLS_EQUI  = 3'd1,
    CLS_ISO   = 3'd2,
    CLS_RIGHT = 3'd3,
    CLS_SCAL  = 3'd4
  } tri_class_t;
endpackage

### sv/triangle_classify_measure.sv
// pipeline of 4 arithmetic stages, one stage per root digit and the perimeter sum stage;
// throughput: one triangle per cycle while the output is not stalled
// the three square roots are digit pipelines, one result bit per stage
// a stall freezes the whole pipeline when its output holds a beat
// rst_n synchronously clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// triangle_classify_measure
// class, Q8 perimeter and doubled area of a triangle from three vertices
// ----------------------------------------------------------------------------
module triangle_classify_measure (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // ax, ay, bx, by, cx, cy
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata   // tri_class, perimeter_q8, area_x2, zero pad
);
  localparam int CB = tcm_pkg::CoordBits;
  localparam int DB = tcm_pkg::DiffBits;
  localparam int QB = tcm_pkg::D2Bits;
  localparam int XB = tcm_pkg::CrossBits;
  localparam int NR = tcm_pkg::RootSteps;
  localparam int RB = tcm_pkg::RootBits;
  localparam int MB = tcm_pkg::RemBits;
  localparam int FB = tcm_pkg::FracBits;

  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 1: differences
  logic v1_r;
  logic signed [DB-1:0] dxb_r, dyb_r, dxc_r, dyc_r, dxbc_r, dybc_r;
  logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
  assign ax = in_tdata[0*CB +: CB];
  assign ay = in_tdata[1*CB +: CB];
  assign bx = in_tdata[2*CB +: CB];
  assign by = in_tdata[3*CB +: CB];
  assign cx = in_tdata[4*CB +: CB];
  assign cy = in_tdata[5*CB +: CB];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
    if (adv) begin
      dxb_r  <= DB'(bx) - DB'(ax);
      dyb_r  <= DB'(by) - DB'(ay);
      dxc_r  <= DB'(cx) - DB'(ax);
      dyc_r  <= DB'(cy) - DB'(ay);
      dxbc_r <= DB'(cx) - DB'(bx);
      dybc_r <= DB'(cy) - DB'(by);
    end
  end

  // stage 2: products
  logic v2_r;
  logic signed [XB-2:0] p1_r, p2_r, sab1_r, sab2_r, sac1_r, sac2_r, sbc1_r, sbc2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      p1_r   <= dxb_r * dyc_r;
      p2_r   <= dyb_r * dxc_r;
      sab1_r <= dxb_r * dxb_r;
      sab2_r <= dyb_r * dyb_r;
      sac1_r <= dxc_r * dxc_r;
      sac2_r <= dyc_r * dyc_r;
      sbc1_r <= dxbc_r * dxbc_r;
      sbc2_r <= dybc_r * dybc_r;
    end
  end

  // stage 3: sums
  logic v3_r;
  logic signed [XB-1:0] cross_r;
  logic [QB-1:0] ab_r, ac_r, bc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      cross_r <= XB'(p1_r) - XB'(p2_r);
      ab_r    <= QB'(unsigned'(sab1_r)) + QB'(unsigned'(sab2_r));
      ac_r    <= QB'(unsigned'(sac1_r)) + QB'(unsigned'(sac2_r));
      bc_r    <= QB'(unsigned'(sbc1_r)) + QB'(unsigned'(sbc2_r));
    end
  end

  // stage 4: class and absolute area
  logic v4_r;
  tcm_pkg::tri_class_t cls_nxt;
  tcm_pkg::tri_class_t cls4_r;
  logic [tcm_pkg::AreaBits-1:0] area4_r;
  logic [QB-1:0] d2_r [3];
  always_comb begin
    if (cross_r == '0) cls_nxt = tcm_pkg::CLS_NONE;
    else if (ab_r == ac_r && ac_r == bc_r) cls_nxt = tcm_pkg::CLS_EQUI;
    else if (ab_r == ac_r || ab_r == bc_r || ac_r == bc_r) cls_nxt = tcm_pkg::CLS_ISO;
    else if ({1'b0, ab_r} + {1'b0, ac_r} == {1'b0, bc_r} ||
             {1'b0, ab_r} + {1'b0, bc_r} == {1'b0, ac_r} ||
             {1'b0, ac_r} + {1'b0, bc_r} == {1'b0, ab_r}) cls_nxt = tcm_pkg::CLS_RIGHT;
    else cls_nxt = tcm_pkg::CLS_SCAL;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) begin
      cls4_r  <= cls_nxt;
      area4_r <= tcm_pkg::AreaBits'(cross_r[XB-1] ? -cross_r : cross_r);
      d2_r[0] <= (cross_r == '0) ? '0 : ab_r;
      d2_r[1] <= (cross_r == '0) ? '0 : ac_r;
      d2_r[2] <= (cross_r == '0) ? '0 : bc_r;
    end
  end

  // root digit pipeline, stage k settles digit RB-1-k of each root
  logic rv_r [NR+1];
  logic [MB-1:0] rem_r [3][NR+1];
  logic [RB-1:0] root_r [3][NR+1];
  logic [QB-1:0] rad_r [3][NR+1];
  tcm_pkg::tri_class_t rcls_r [NR+1];
  logic [tcm_pkg::AreaBits-1:0] rarea_r [NR+1];

  assign rv_r[0] = v4_r;
  assign rcls_r[0] = cls4_r;
  assign rarea_r[0] = area4_r;
  for (genvar s = 0; s < 3; s++) begin : g_side
    assign rem_r[s][0]  = '0;
    assign root_r[s][0] = '0;
    assign rad_r[s][0]  = d2_r[s];
    for (genvar k = 0; k < NR; k++) begin : g_dig
      localparam int I = RB - 1 - k;
      logic [1:0] pair;
      logic [MB-1:0] cur, trial;
      if (I >= FB && 2 * (I - FB) + 1 < QB) begin : g_p
        assign pair = rad_r[s][k][2*(I-FB) +: 2];
      end else if (I >= FB && 2 * (I - FB) < QB) begin : g_h
        assign pair = {1'b0, rad_r[s][k][2*(I-FB)]};
      end else begin : g_z
        assign pair = 2'b00;
      end
      assign cur   = {rem_r[s][k][MB-3:0], pair};
      assign trial = {root_r[s][k][MB-3:0], 2'b01};
      always_ff @(posedge clk) begin
        if (adv) begin
          rad_r[s][k+1] <= rad_r[s][k];
          if (cur >= trial) begin
            rem_r[s][k+1]  <= cur - trial;
            root_r[s][k+1] <= {root_r[s][k][RB-2:0], 1'b1};
          end else begin
            rem_r[s][k+1]  <= cur;
            root_r[s][k+1] <= {root_r[s][k][RB-2:0], 1'b0};
          end
        end
      end
    end
  end
  for (genvar k = 0; k < NR; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) rv_r[k+1] <= 1'b0;
      else if (adv) rv_r[k+1] <= rv_r[k];
      if (adv) begin
        rcls_r[k+1]  <= rcls_r[k];
        rarea_r[k+1] <= rarea_r[k];
      end
    end
  end

  // output stage: perimeter sum
  logic vo_r;
  tcm_pkg::tri_class_t clso_r;
  logic [tcm_pkg::PerimBits-1:0] perim_r;
  logic [tcm_pkg::AreaBits-1:0] areao_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (adv) vo_r <= rv_r[NR];
    if (adv) begin
      clso_r  <= rcls_r[NR];
      areao_r <= rarea_r[NR];
      perim_r <= tcm_pkg::PerimBits'(root_r[0][NR] + root_r[1][NR] + root_r[2][NR]);
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {1'b0, areao_r, perim_r, clso_r};
endmodule

### sv/tcm_checker.sv
// ----------------------------------------------------------------------------
// tcm_checker
// port-level checks of the triangle classifier
// ----------------------------------------------------------------------------
`include "triangle_classify_measure_macros.svh"
module tcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  `TCM_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `TCM_ASSERT_IMP(a_ready, 1'b1, in_tready == (!out_tvalid || out_tready))
  `TCM_ASSERT_IMP(a_none, out_tvalid && out_tdata[2:0] == tcm_pkg::CLS_NONE, out_tdata[62:3] == '0)
  `TCM_ASSERT_IMP(a_area, out_tvalid && out_tdata[2:0] != tcm_pkg::CLS_NONE, out_tdata[62:30] != '0)
endmodule

bind triangle_classify_measure tcm_checker u_tcm_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
